// File: hw/rtl/lfsc_pkg.sv
`timescale 1ns / 1ps

package lfsc_pkg;

	localparam int ROWS         = 8;
	localparam int DEF_DISPLAYS = 8;
	localparam int DEF_FRAMES   = 8;
	localparam logic [3:0] SPLIT_MAX = 4'd8;

	typedef enum logic [1:0] {
		MODE_WRITE  = 2'd0,
		MODE_FULL   = 2'd1,
		MODE_VSPLIT = 2'd2,
		MODE_HSPLIT = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [2:0] display_sel;
		logic [2:0] frame_a;
		logic [2:0] frame_b;
		logic [3:0] split_amount;
		logic [2:0] row_sel;
		logic [7:0] row_bits_in;
	} in_t;

	typedef struct packed {
		logic [2:0] display_out;
		logic [2:0] row_index;
		logic [7:0] row_pixels;
		logic       last_row;
	} out_t;

endpackage

// File: hw/rtl/lfsc_frame_mem.sv
`timescale 1ns / 1ps

// Frame row store: one write port, two registered read ports.
module lfsc_frame_mem #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [7:0]    rdata0,
	output logic [7:0]    rdata1
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

// File: hw/rtl/led_frame_split_compositor_top.sv
`timescale 1ns / 1ps

// LED frame split compositor. Holds FRAMES 8x8 one-bit frames for each of
// DISPLAYS matrices in one row store. After reset the store is swept to zero,
// one row a cycle, over all DISPLAYS*FRAMES*8 rows (512 at the defaults);
// busy stays high throughout. An item is taken when start is high and busy is
// low. A write item stores one row in the cycle it is taken and gives no
// result; write items may follow one another every cycle. A show item (full,
// vertical split or horizontal split) holds busy while its eight rows are
// read, two store ports per row, and the next item can be taken once they
// have all been read. Its rows come out on consecutive cycles on result,
// each marked by a one-cycle strobe, after passing through the read stage
// and the result register, row 7 flagged by last_row. There is no
// back-pressure: the receiver must take every row in the cycle it is shown.
// Displays or frames beyond the configured count read as zero and writes to
// them are dropped; split amounts above eight act as eight.
module led_frame_split_compositor_top #(
	parameter int DISPLAYS = lfsc_pkg::DEF_DISPLAYS,
	parameter int FRAMES   = lfsc_pkg::DEF_FRAMES
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  lfsc_pkg::in_t  cmd,
	output logic           strobe,
	output lfsc_pkg::out_t result
);

	localparam int DEPTH = DISPLAYS * FRAMES * lfsc_pkg::ROWS;
	localparam int AW    = $clog2(DEPTH);

	// one-hot sequencer
	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_SHOW  = 3'b100
	} state_t;

	state_t          st_q;
	logic [AW-1:0]   clr_cnt_q;
	logic [2:0]      row_cnt_q;
	lfsc_pkg::in_t   item_q;

	// read stage
	logic            valid_s1;
	logic [2:0]      row_s1;
	logic [2:0]      disp_s1;
	lfsc_pkg::mode_t mode_s1;
	logic [3:0]      split_s1;
	logic            zero0_s1;
	logic            zero1_s1;

	logic            strobe_q;
	lfsc_pkg::out_t  result_q;

	logic            accept;
	logic [3:0]      split_clamped;
	lfsc_pkg::in_t   cmd_clamped;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [7:0]      mem_wdata;
	logic [AW-1:0]   raddr0, raddr1;
	logic [7:0]      rdata0, rdata1;
	logic [3:0]      vsum;
	logic [2:0]      frame0, row0;
	logic            ok0, ok1;
	logic [7:0]      px0, px1;
	logic [15:0]     hcat;
	logic [7:0]      pix;

	function automatic logic [AW-1:0] row_addr(input logic [2:0] d, input logic [2:0] f,
		input logic [2:0] r);
		return AW'((int'(d) * FRAMES + int'(f)) * lfsc_pkg::ROWS + int'(r));
	endfunction

	function automatic logic in_range(input logic [2:0] d, input logic [2:0] f);
		return (int'(d) < DISPLAYS) && (int'(f) < FRAMES);
	endfunction

	assign busy   = (st_q != ST_IDLE);
	assign accept = start && !busy;

	assign split_clamped = (cmd.split_amount > lfsc_pkg::SPLIT_MAX) ?
		lfsc_pkg::SPLIT_MAX : cmd.split_amount;

	always_comb begin
		cmd_clamped              = cmd;
		cmd_clamped.split_amount = split_clamped;
	end

	// write port: clearing sweep, or a write item in its accept cycle
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_cnt_q;
		mem_wdata = 8'h00;
		if (st_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (accept && cmd.mode == lfsc_pkg::MODE_WRITE &&
			in_range(cmd.display_sel, cmd.frame_a)) begin
			mem_we    = 1'b1;
			mem_waddr = row_addr(cmd.display_sel, cmd.frame_a, cmd.row_sel);
			mem_wdata = cmd.row_bits_in;
		end
	end

	// port 0 fetches A (or the A/B mix of a vertical split), port 1 fetches B
	always_comb begin
		vsum   = {1'b0, row_cnt_q} + item_q.split_amount;
		frame0 = item_q.frame_a;
		row0   = row_cnt_q;
		if (item_q.mode == lfsc_pkg::MODE_VSPLIT) begin
			frame0 = vsum[3] ? item_q.frame_b : item_q.frame_a;
			row0   = vsum[2:0];
		end
		ok0    = in_range(item_q.display_sel, frame0);
		ok1    = in_range(item_q.display_sel, item_q.frame_b);
		raddr0 = ok0 ? row_addr(item_q.display_sel, frame0, row0) : '0;
		raddr1 = ok1 ? row_addr(item_q.display_sel, item_q.frame_b, row_cnt_q) : '0;
	end

	lfsc_frame_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr0(raddr0),
		.raddr1(raddr1),
		.rdata0(rdata0),
		.rdata1(rdata1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLEAR;
			clr_cnt_q <= '0;
			row_cnt_q <= '0;
		end else begin
			unique case (st_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					row_cnt_q <= '0;
					if (accept && cmd.mode != lfsc_pkg::MODE_WRITE) begin
						st_q <= ST_SHOW;
					end
				end
				ST_SHOW: begin
					row_cnt_q <= row_cnt_q + 1'b1;
					if (row_cnt_q == 3'(lfsc_pkg::ROWS - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cmd_clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			valid_s1 <= (st_q == ST_SHOW);
			strobe_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		row_s1   <= row_cnt_q;
		disp_s1  <= item_q.display_sel;
		mode_s1  <= item_q.mode;
		split_s1 <= item_q.split_amount;
		zero0_s1 <= !ok0;
		zero1_s1 <= !ok1;
	end

	// compose: horizontal split is the top byte of {A,B} shifted left by s
	always_comb begin
		px0  = zero0_s1 ? 8'h00 : rdata0;
		px1  = zero1_s1 ? 8'h00 : rdata1;
		hcat = {px0, px1} << split_s1;
		pix  = (mode_s1 == lfsc_pkg::MODE_HSPLIT) ? hcat[15:8] : px0;
	end

	always_ff @(posedge clk) begin
		result_q.display_out <= disp_s1;
		result_q.row_index   <= row_s1;
		result_q.row_pixels  <= pix;
		result_q.last_row    <= (row_s1 == 3'(lfsc_pkg::ROWS - 1));
	end

	assign strobe = strobe_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// no store write may land while a show is still reading
	a_no_write_in_show: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SHOW) |-> !mem_we)
		else $error("store written during show");

	// rows of a show come out back to back
	a_rows_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last_row) |=> strobe)
		else $error("gap inside a show burst");

	// a row other than the first always follows another row
	a_rows_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.row_index != 3'd0) |-> $past(strobe))
		else $error("row emitted out of sequence");

	// the last flag marks row seven only
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.last_row == (result.row_index == 3'd7)))
		else $error("last_row mismatch");

	// nothing is emitted during the clearing sweep
	a_quiet_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLEAR) |-> !strobe && !valid_s1)
		else $error("result during clear");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

// Testbench for the LED frame split compositor.
// Items go in through the start/busy handshake; each show item answers with
// eight rows on consecutive strobes, which cannot be held off, so every row
// is compared as it appears against a queue of rows worked out here from a
// private copy of the frame store.
module testbench;

	localparam int N_DISPLAYS  = 8;
	localparam int N_FRAMES    = 8;
	localparam int ROWS        = lfsc_pkg::ROWS;
	localparam int CLK_HALF    = 5;
	// Generous bound on the whole run: the store sweep after reset plus ~180
	// items, each with its random idle gap and, for shows, its busy time.
	localparam int CYCLE_LIMIT = 100000;
	localparam int MAX_PRINTS  = 30;
	localparam int DRAIN_WAIT  = 20;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	lfsc_pkg::in_t  cmd;
	logic           strobe;
	lfsc_pkg::out_t result;

	// Private copy of the frame store, one byte per row, bit 7 is column 0.
	logic [7:0] frame_rows [N_DISPLAYS * N_FRAMES * ROWS];
	// Rows still to come from the block, oldest first.
	lfsc_pkg::out_t rows_due [$];

	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned writes_sent;
	int unsigned shows_sent;
	int unsigned rows_checked;

	// Where the random traffic is focused, so that shows mostly land on
	// frames that have been written.
	logic [2:0] focus_disp;
	logic [2:0] focus_frames [2];

	led_frame_split_compositor_top #(
		.DISPLAYS(N_DISPLAYS),
		.FRAMES  (N_FRAMES)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.strobe(strobe),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Hard stop in case the block hangs or drops rows.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d rows outstanding",
			         cycle_count, rows_due.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int unsigned got,
	                               input int unsigned want);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// Store read; displays or frames beyond the configured counts read as zero.
	function automatic int unsigned stored_row(input int unsigned disp,
	                                           input int unsigned frame,
	                                           input int unsigned row);
		if (disp >= N_DISPLAYS || frame >= N_FRAMES || row >= ROWS)
			return 0;
		return 32'(frame_rows[(disp * N_FRAMES + frame) * ROWS + row]);
	endfunction

	// Applies one accepted item to the private store, or queues the eight
	// composed rows it must produce.
	task automatic compose_item(input lfsc_pkg::in_t c);
		int unsigned s;
		int unsigned px;
		int unsigned disp;
		int unsigned fa;
		int unsigned fb;
		lfsc_pkg::out_t row_out;
		disp = 32'(c.display_sel);
		fa   = 32'(c.frame_a);
		fb   = 32'(c.frame_b);
		s    = (c.split_amount > lfsc_pkg::SPLIT_MAX) ? 32'(lfsc_pkg::SPLIT_MAX) :
		       32'(c.split_amount);
		if (c.mode == lfsc_pkg::MODE_WRITE) begin
			if (disp < N_DISPLAYS && fa < N_FRAMES)
				frame_rows[(disp * N_FRAMES + fa) * ROWS + 32'(c.row_sel)] =
					c.row_bits_in;
			writes_sent++;
			return;
		end
		shows_sent++;
		for (int unsigned r = 0; r < ROWS; r++) begin
			case (c.mode)
				lfsc_pkg::MODE_FULL: begin
					px = stored_row(disp, fa, r);
				end
				lfsc_pkg::MODE_VSPLIT: begin
					// top rows from A moved up by s, the rest from the top of B
					if (r < ROWS - s)
						px = stored_row(disp, fa, r + s);
					else
						px = stored_row(disp, fb, r - (ROWS - s));
				end
				default: begin
					// plain unsigned shifts, no sign fill
					px = (stored_row(disp, fa, r) << s) |
					     (stored_row(disp, fb, r) >> (ROWS - s));
				end
			endcase
			row_out.display_out = c.display_sel;
			row_out.row_index   = 3'(r);
			row_out.row_pixels  = 8'(px);
			row_out.last_row    = (r == ROWS - 1);
			rows_due.push_back(row_out);
		end
	endtask

	// Result checker. Outputs are sampled at the edge that ends the strobe cycle.
	always @(posedge clk) begin
		lfsc_pkg::out_t want;
		if (arst_n && strobe) begin
			if (rows_due.size() == 0) begin
				report_mismatch("row with none due (pixels)", 32'(result.row_pixels), 0);
			end else begin
				want = rows_due.pop_front();
				rows_checked++;
				if (result.display_out !== want.display_out)
					report_mismatch("display_out", 32'(result.display_out),
					                32'(want.display_out));
				if (result.row_index !== want.row_index)
					report_mismatch("row_index", 32'(result.row_index),
					                32'(want.row_index));
				if (result.row_pixels !== want.row_pixels)
					report_mismatch("row_pixels", 32'(result.row_pixels),
					                32'(want.row_pixels));
				if (result.last_row !== want.last_row)
					report_mismatch("last_row", 32'(result.last_row),
					                32'(want.last_row));
			end
		end
	end

	// Presents one item, waits for it to be taken, then may idle for a random
	// gap chosen up to max_gap. When the gap is zero start simply stays high for the next item.
	task automatic send_item(input lfsc_pkg::in_t c, input int unsigned max_gap);
		int unsigned gap;
		cmd   <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		compose_item(c);
		gap = $urandom_range(0, max_gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic lfsc_pkg::in_t make_item(input lfsc_pkg::mode_t m,
	                                            input logic [2:0] disp,
	                                            input logic [2:0] fa, input logic [2:0] fb,
	                                            input logic [3:0] s, input logic [2:0] row,
	                                            input logic [7:0] bits);
		lfsc_pkg::in_t c;
		c.mode         = m;
		c.display_sel  = disp;
		c.frame_a      = fa;
		c.frame_b      = fb;
		c.split_amount = s;
		c.row_sel      = row;
		c.row_bits_in  = bits;
		return c;
	endfunction

	function automatic logic [2:0] pick_frame();
		if ($urandom_range(0, 4) == 0)
			return 3'($urandom);
		return focus_frames[$urandom_range(0, 1)];
	endfunction

	// Random item, mostly aimed at the focus display and frames.
	function automatic lfsc_pkg::in_t random_item(input int unsigned write_pct);
		lfsc_pkg::mode_t m;
		logic [2:0] disp;
		m    = ($urandom_range(0, 99) < write_pct) ? lfsc_pkg::MODE_WRITE :
		       lfsc_pkg::mode_t'($urandom_range(1, 3));
		disp = ($urandom_range(0, 4) == 0) ? 3'($urandom) : focus_disp;
		return make_item(m, disp, pick_frame(), pick_frame(), 4'($urandom),
		                 3'($urandom), 8'($urandom));
	endfunction

	task automatic refocus();
		focus_disp      = 3'($urandom);
		focus_frames[0] = 3'($urandom);
		focus_frames[1] = 3'($urandom);
	endtask

	// Extremes of every field, each mode, splits of zero, eight and beyond,
	// the top display and frame, and a frame never written since reset.
	task automatic test_directed();
		send_item(make_item(lfsc_pkg::MODE_WRITE, 3'd0, 3'd0, 3'd0, 4'd0, 3'd0, 8'hFF), 3);
		send_item(make_item(lfsc_pkg::MODE_WRITE, 3'd0, 3'd0, 3'd0, 4'd0, 3'd7, 8'h81), 3);
		send_item(make_item(lfsc_pkg::MODE_WRITE, 3'd0, 3'd1, 3'd0, 4'd0, 3'd0, 8'h80), 3);
		send_item(make_item(lfsc_pkg::MODE_WRITE, 3'd0, 3'd1, 3'd0, 4'd0, 3'd7, 8'h01), 3);
		send_item(make_item(lfsc_pkg::MODE_WRITE, 3'd7, 3'd7, 3'd7, 4'd15, 3'd3, 8'hA5), 3);
		send_item(make_item(lfsc_pkg::MODE_WRITE, 3'd7, 3'd6, 3'd7, 4'd15, 3'd7, 8'h5A), 3);
		send_item(make_item(lfsc_pkg::MODE_FULL,   3'd0, 3'd0, 3'd7, 4'd0,  3'd0, 8'h00), 3);
		send_item(make_item(lfsc_pkg::MODE_FULL,   3'd7, 3'd7, 3'd0, 4'd15, 3'd7, 8'hFF), 3);
		// frame untouched since reset reads as zero
		send_item(make_item(lfsc_pkg::MODE_FULL,   3'd3, 3'd2, 3'd0, 4'd0,  3'd0, 8'h00), 3);
		send_item(make_item(lfsc_pkg::MODE_VSPLIT, 3'd0, 3'd0, 3'd1, 4'd0,  3'd0, 8'h00), 3);
		send_item(make_item(lfsc_pkg::MODE_VSPLIT, 3'd0, 3'd0, 3'd1, 4'd8,  3'd0, 8'h00), 3);
		send_item(make_item(lfsc_pkg::MODE_VSPLIT, 3'd0, 3'd0, 3'd1, 4'd15, 3'd0, 8'h00), 3);
		send_item(make_item(lfsc_pkg::MODE_VSPLIT, 3'd0, 3'd0, 3'd1, 4'd3,  3'd0, 8'h00), 3);
		send_item(make_item(lfsc_pkg::MODE_VSPLIT, 3'd7, 3'd7, 3'd6, 4'd1,  3'd0, 8'h00), 3);
		send_item(make_item(lfsc_pkg::MODE_HSPLIT, 3'd0, 3'd0, 3'd1, 4'd0,  3'd0, 8'h00), 3);
		send_item(make_item(lfsc_pkg::MODE_HSPLIT, 3'd0, 3'd0, 3'd1, 4'd8,  3'd0, 8'h00), 3);
		send_item(make_item(lfsc_pkg::MODE_HSPLIT, 3'd0, 3'd1, 3'd0, 4'd9,  3'd0, 8'h00), 3);
		send_item(make_item(lfsc_pkg::MODE_HSPLIT, 3'd0, 3'd1, 3'd0, 4'd4,  3'd0, 8'h00), 3);
		send_item(make_item(lfsc_pkg::MODE_HSPLIT, 3'd7, 3'd7, 3'd6, 4'd7,  3'd0, 8'h00), 3);
	endtask

	// Fill two frames of one display completely, then show them every way.
	task automatic test_frame_sequences(input int unsigned sets);
		logic [2:0] disp;
		logic [2:0] fa;
		logic [2:0] fb;
		for (int unsigned k = 0; k < sets; k++) begin
			disp = 3'($urandom);
			fa   = 3'($urandom);
			fb   = 3'($urandom);
			for (int unsigned r = 0; r < ROWS; r++) begin
				send_item(make_item(lfsc_pkg::MODE_WRITE, disp, fa, 3'($urandom),
				                    4'($urandom), 3'(r), 8'($urandom)), 13);
				send_item(make_item(lfsc_pkg::MODE_WRITE, disp, fb, 3'($urandom),
				                    4'($urandom), 3'(r), 8'($urandom)), 13);
			end
			send_item(make_item(lfsc_pkg::MODE_FULL, disp, fa, fb, 4'($urandom),
			                    3'($urandom), 8'($urandom)), 13);
			send_item(make_item(lfsc_pkg::MODE_VSPLIT, disp, fa, fb,
			                    4'($urandom_range(0, 15)), 3'($urandom), 8'($urandom)), 13);
			send_item(make_item(lfsc_pkg::MODE_HSPLIT, disp, fa, fb,
			                    4'($urandom_range(0, 15)), 3'($urandom), 8'($urandom)), 13);
		end
	endtask

	// Mixed writes and shows with random idling on the sender side.
	task automatic test_random_traffic(input int unsigned count, input int unsigned max_gap);
		for (int unsigned k = 0; k < count; k++) begin
			if ($urandom_range(0, 19) == 0)
				refocus();
			send_item(random_item(50), max_gap);
		end
	endtask

	// Sender holds off until every due row has come out, then carries on.
	task automatic test_drain_pause(input int unsigned count);
		start <= 1'b0;
		@(posedge clk);
		while (rows_due.size() != 0) @(posedge clk);
		test_random_traffic(count, 13);
	endtask

	initial begin
		start        = 1'b0;
		cmd          = '0;
		arst_n       = 1'b0;
		error_count  = 0;
		cycle_count  = 0;
		writes_sent  = 0;
		shows_sent   = 0;
		rows_checked = 0;
		for (int unsigned i = 0; i < N_DISPLAYS * N_FRAMES * ROWS; i++)
			frame_rows[i] = 8'h00;
		refocus();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// busy covers the store sweep, so the first item just waits for it
		test_directed();
		test_frame_sequences(3);
		test_random_traffic(40, 13);
		// back-to-back items with no idling at all
		test_random_traffic(40, 0);
		test_drain_pause(25);

		start <= 1'b0;
		while (rows_due.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Covered %0d row writes and %0d show items (full, vertical, horizontal split),",
		         writes_sent, shows_sent);
		$display("%0d composed rows compared, %0d mismatches", rows_checked, error_count);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/lfsc_pkg.sv
hw/rtl/lfsc_frame_mem.sv
hw/rtl/led_frame_split_compositor_top.sv
tb/testbench.sv
